/* src/modal_resonator_bank_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the modal resonator bank.
// Each macro takes a label, an antecedent, a consequent and a message.
// ---------------------------------------------------------------------------
`ifndef MODAL_RESONATOR_BANK_TOP_MACROS_SVH
`define MODAL_RESONATOR_BANK_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mrb_pkg.sv */
// ---------------------------------------------------------------------------
// mrb_pkg
// Shared types, codes and constants of the modal resonator bank.
// ---------------------------------------------------------------------------
`default_nettype none

package mrb_pkg;

	localparam int MRB_NUM_MODES = 10;
	localparam int MRB_ACC_W     = 36;
	localparam int MRB_OUT_SHIFT = 26;

	// 0.99965 in signed Q1.30.
	localparam logic signed [31:0] MRB_RELEASE_Q30 = 32'sd1073366014;
	localparam logic [14:0]        MRB_OUT_SCALE   = 15'd23000;

	localparam logic [17:0] MRB_LIMIT_RESET     = 18'd44100;
	localparam logic [14:0] MRB_THRESHOLD_RESET = 15'd50;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SILENCE_LIMIT     = 2'd0;
	localparam logic [1:0] CFG_SILENCE_THRESHOLD = 2'd1;

	// Request commands.
	localparam logic [1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [1:0] CMD_COEF    = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	// Coefficient selectors.
	localparam logic [1:0] SEL_FB_ONE = 2'd0;
	localparam logic [1:0] SEL_FB_TWO = 2'd1;
	localparam logic [1:0] SEL_GAIN   = 2'd2;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_MUL_GAIN,
		OP_MUL_FB1,
		OP_MUL_FB2,
		OP_SATURATE,
		OP_MUL_REL,
		OP_COMMIT
	} mrb_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAIN,
		ST_FB1,
		ST_FB2,
		ST_SAT,
		ST_REL,
		ST_COMMIT,
		ST_SUM,
		ST_ABS,
		ST_SCALE,
		ST_FINISH
	} mrb_state_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		mrb_op_t            op;
		logic               release_on;
		logic               restart;
		logic               coef_we;
		logic [3:0]         coef_slot;
		logic [1:0]         coef_sel;
		logic signed [31:0] coef_value;
		logic signed [15:0] excitation;
	} mrb_cell_ctrl_t;

endpackage

`default_nettype wire

/* src/mrb_cell.sv */
// ---------------------------------------------------------------------------
// mrb_cell
// One two-pole resonator with its own multiplier and a stage of the sum chain.
// ---------------------------------------------------------------------------
`default_nettype none

module mrb_cell #(
	parameter int CELL_IDX = 0,
	parameter int SUM_W    = 36
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mrb_pkg::mrb_cell_ctrl_t ctrl,
	input  wire logic signed [SUM_W-1:0] psum_in,
	output logic signed [SUM_W-1:0]      psum_out
);
	import mrb_pkg::*;

	logic signed [31:0] fb1_q, fb2_q, gain_q;
	logic signed [31:0] y1_q, y2_q;
	logic signed [31:0] y_q, out_q;
	logic signed [63:0] prod_q;
	logic signed [MRB_ACC_W-1:0] acc_q;
	logic signed [SUM_W-1:0] psum_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [MRB_ACC_W-1:0] term16, term30, acc_sum;
	logic signed [31:0] y_sat, y_final;
	logic               slot_hit;

	assign slot_hit = ({1'b0, ctrl.coef_slot} == 5'(CELL_IDX));

	always_comb begin
		case (ctrl.op)
			OP_MUL_GAIN: begin
				mul_a = gain_q;
				mul_b = 32'($signed(ctrl.excitation));
			end
			OP_MUL_FB1: begin
				mul_a = fb1_q;
				mul_b = y1_q;
			end
			OP_MUL_FB2: begin
				mul_a = fb2_q;
				mul_b = y2_q;
			end
			OP_MUL_REL: begin
				mul_a = y_q;
				mul_b = MRB_RELEASE_Q30;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Floor shifts of the registered product.
	assign term16  = MRB_ACC_W'($signed(prod_q[47:16]));
	assign term30  = MRB_ACC_W'($signed(prod_q[63:30]));
	assign acc_sum = acc_q + term30;

	always_comb begin
		if ((acc_sum[MRB_ACC_W-1:31] == '0) || (acc_sum[MRB_ACC_W-1:31] == '1)) begin
			y_sat = acc_sum[31:0];
		end else if (acc_sum[MRB_ACC_W-1]) begin
			y_sat = 32'sh8000_0000;
		end else begin
			y_sat = 32'sh7FFF_FFFF;
		end
	end

	// The release factor is below one, so the scaled value always fits.
	assign y_final = ctrl.release_on ? $signed(prod_q[61:30]) : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb1_q  <= '0;
			fb2_q  <= '0;
			gain_q <= '0;
			y1_q   <= '0;
			y2_q   <= '0;
		end else begin
			if (ctrl.coef_we && slot_hit) begin
				case (ctrl.coef_sel)
					SEL_FB_ONE: fb1_q  <= ctrl.coef_value;
					SEL_FB_TWO: fb2_q  <= ctrl.coef_value;
					SEL_GAIN:   gain_q <= ctrl.coef_value;
					default:    ;
				endcase
			end
			if (ctrl.restart) begin
				y1_q <= '0;
				y2_q <= '0;
			end else if (ctrl.op == OP_COMMIT) begin
				y2_q <= y1_q;
				y1_q <= y_final;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		psum_q <= psum_in + SUM_W'(out_q);
		case (ctrl.op)
			OP_MUL_FB1:  acc_q <= term16;
			OP_MUL_FB2:  acc_q <= acc_sum;
			OP_SATURATE: y_q   <= y_sat;
			OP_COMMIT:   out_q <= y_final;
			default:     ;
		endcase
	end

	assign psum_out = psum_q;

endmodule

`default_nettype wire

/* src/modal_resonator_bank_top.sv */
// An audio sample request with the voice on runs the six-step multiply sequence of the
// cells, the walk of the partial sum down the cell chain, then the magnitude, scaling and
// finish states; with the voice off it goes straight to the finish state and gives a zero
// result. No new request is taken until the finished sample is in the output register.
// Coefficient, release and restart requests start no sequence and need no output slot.
// Reset clears coefficients, mode states and voice status and loads the register defaults.
// ---------------------------------------------------------------------------
// modal_resonator_bank_top
// Bank of two-pole resonators built as a chain of cells, with output scaling,
// saturation and silence detection.
// ---------------------------------------------------------------------------
`default_nettype none

module modal_resonator_bank_top #(
	parameter int NUM_MODES = mrb_pkg::MRB_NUM_MODES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Request channel.
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [15:0] excitation,
	input  wire logic [3:0]         mode_slot,
	input  wire logic [1:0]         coef_select,
	input  wire logic signed [31:0] coef_value,
	// Result channel.
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      audio_sample,
	output logic                    voice_active,
	// Configuration write port.
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [17:0]        cfg_data
);
	import mrb_pkg::*;

	// The mode sum needs enough headroom for NUM_MODES full-scale states.
	localparam int SUM_W = 32 + $clog2(NUM_MODES);
	localparam int CNT_W = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
	localparam int PROD_W = SUM_W + 15;
	localparam int SHR_W = PROD_W - MRB_OUT_SHIFT;

	mrb_state_t state_q, state_d;
	mrb_op_t    op_d;

	logic accept;
	logic finish_go;

	logic        voice_on_q;
	logic        release_q;
	logic [17:0] quiet_cnt_q;
	logic [17:0] limit_q;
	logic [14:0] thr_q;
	logic        mute_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [15:0] x_q;
	logic [SUM_W-1:0]   mag_q;
	logic               neg_q;
	logic [PROD_W-1:0]  scaled_q;

	logic               out_valid_q;
	logic signed [15:0] audio_q;
	logic               active_q;

	mrb_cell_ctrl_t ctrl;
	logic signed [SUM_W-1:0] psum [NUM_MODES+1];

	logic signed [SUM_W-1:0] sum_total;
	logic [SHR_W-1:0]        shifted;
	logic [16:0]             sat_lim;
	logic [16:0]             mag17;
	logic signed [15:0]      sample16;
	logic                    quiet;
	logic                    goes_silent;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// -----------------------------------------------------------------------
	// Sequencer. Every cell runs the same step in lockstep: input gain
	// product, two feedback products, saturation, the release product and
	// the state update. After that the partial sum walks down the chain,
	// one cell per cycle, and the last cell's sum goes to the output scaler.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		finish_go = 1'b0;
		op_d      = OP_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_SAMPLE)) begin
					state_d = voice_on_q ? ST_GAIN : ST_FINISH;
				end
			end
			ST_GAIN: begin
				op_d    = OP_MUL_GAIN;
				state_d = ST_FB1;
			end
			ST_FB1: begin
				op_d    = OP_MUL_FB1;
				state_d = ST_FB2;
			end
			ST_FB2: begin
				op_d    = OP_MUL_FB2;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				op_d    = OP_SATURATE;
				state_d = ST_REL;
			end
			ST_REL: begin
				op_d    = OP_MUL_REL;
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				op_d    = OP_COMMIT;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				if (cnt_q == CNT_W'(NUM_MODES - 1)) begin
					state_d = ST_ABS;
				end
			end
			ST_ABS: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// Hold the finished sample until the output register is free.
				if (!(out_valid_q && out_stall)) begin
					finish_go = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Coefficient writes and restarts reach the cells in the cycle they are
	// accepted; the excitation is held in a register for the whole sequence.
	assign ctrl.op         = op_d;
	assign ctrl.release_on = release_q;
	assign ctrl.restart    = accept && (cmd == CMD_RESTART);
	assign ctrl.coef_we    = accept && (cmd == CMD_COEF);
	assign ctrl.coef_slot  = mode_slot;
	assign ctrl.coef_sel   = coef_select;
	assign ctrl.coef_value = coef_value;
	assign ctrl.excitation = x_q;

	// -----------------------------------------------------------------------
	// Cell chain.
	// -----------------------------------------------------------------------
	assign psum[0] = '0;

	for (genvar i = 0; i < NUM_MODES; i++) begin : g_cell
		mrb_cell #(
			.CELL_IDX (i),
			.SUM_W    (SUM_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.psum_in  (psum[i]),
			.psum_out (psum[i+1])
		);
	end

	assign sum_total = psum[NUM_MODES];

	// -----------------------------------------------------------------------
	// Output scaling. The sum is split into sign and magnitude so that the
	// shift by 26 truncates toward zero. The magnitude limit is one larger
	// for negative samples, which lets -32768 through.
	// -----------------------------------------------------------------------
	assign shifted  = scaled_q[PROD_W-1:MRB_OUT_SHIFT];
	assign sat_lim  = neg_q ? 17'd32768 : 17'd32767;
	assign mag17    = (shifted > SHR_W'(sat_lim)) ? sat_lim : shifted[16:0];
	assign sample16 = neg_q ? $signed(16'(17'd0 - mag17)) : $signed(mag17[15:0]);
	assign quiet    = (mag17 < {2'b00, thr_q});

	// A quiet sample that comes after the tolerated run ends the voice.
	assign goes_silent = quiet && (quiet_cnt_q >= limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_on_q  <= 1'b0;
			release_q   <= 1'b0;
			quiet_cnt_q <= '0;
			limit_q     <= MRB_LIMIT_RESET;
			thr_q       <= MRB_THRESHOLD_RESET;
			mute_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SILENCE_LIMIT:     limit_q <= cfg_data;
					CFG_SILENCE_THRESHOLD: thr_q   <= cfg_data[14:0];
					default:               ;
				endcase
			end

			if (accept) begin
				case (cmd)
					CMD_SAMPLE:  mute_q <= !voice_on_q;
					CMD_RELEASE: release_q <= 1'b1;
					CMD_RESTART: begin
						voice_on_q  <= 1'b1;
						release_q   <= 1'b0;
						quiet_cnt_q <= '0;
					end
					default:     ;
				endcase
			end

			if (state_q == ST_COMMIT) begin
				cnt_q <= '0;
			end else if (state_q == ST_SUM) begin
				cnt_q <= cnt_q + 1'b1;
			end

			// A new result may replace one that is taken in the same cycle.
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (finish_go && !mute_q) begin
				if (!quiet) begin
					quiet_cnt_q <= '0;
				end else if (goes_silent) begin
					voice_on_q <= 1'b0;
				end else begin
					quiet_cnt_q <= quiet_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_SAMPLE)) begin
			x_q <= excitation;
		end
		if (state_q == ST_ABS) begin
			neg_q <= sum_total[SUM_W-1];
			mag_q <= sum_total[SUM_W-1] ? SUM_W'(-sum_total) : SUM_W'(sum_total);
		end
		if (state_q == ST_SCALE) begin
			scaled_q <= PROD_W'(mag_q) * PROD_W'(MRB_OUT_SCALE);
		end
		if (finish_go) begin
			if (mute_q) begin
				audio_q  <= '0;
				active_q <= 1'b0;
			end else begin
				audio_q  <= sample16;
				active_q <= !goes_silent;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign audio_sample = audio_q;
	assign voice_active = active_q;

endmodule

`default_nettype wire

/* src/mrb_checker.sv */
// ---------------------------------------------------------------------------
// mrb_checker
// Port-level checks of the modal resonator bank, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "modal_resonator_bank_top_macros.svh"

module mrb_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [1:0]         cmd,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] audio_sample,
	input wire logic               voice_active
);
	import mrb_pkg::*;

	// A stalled result keeps its value until it is taken.
	`MRB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(audio_sample) && $stable(voice_active),
		"stalled result changed")

	// An accepted audio sample occupies the block in the next cycle.
	`MRB_ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && (cmd == CMD_SAMPLE),
		in_stall, "block idle right after an audio sample request")

	// A new result is only produced while the block was working on a sample.
	`MRB_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall),
		"result appeared without a sample in progress")

endmodule

bind modal_resonator_bank_top mrb_checker u_mrb_checker (.*);

`default_nettype wire

/* verif/modal_resonator_bank_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modal_resonator_bank_top_tb
// Self-checking bench for the modal resonator bank. A transaction-level predictor
// of the resonator bank runs beside the block. Directed requests cover the
// corner cases. Random note sequences then run under several idle and stall
// patterns and register settings, and a long output hold fills the block.
// ---------------------------------------------------------------------------
module modal_resonator_bank_top_tb;
	import mrb_pkg::*;

	localparam int NUM_MODES = MRB_NUM_MODES;
	// Settling pause that follows the last delivered sample.
	localparam int SETTLE_CYCLES = 2 * (NUM_MODES + 10);
	// Watchdog limit for the whole run, with ample margin for a correct run.
	localparam int CYCLE_LIMIT = 500000;
	// Counted requests per random traffic phase, four phases in all.
	localparam int PHASE_ITEMS = 225;

	// Register indexes that the block does not implement.
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;
	// Coefficient selector that names no coefficient.
	localparam logic [1:0] SEL_NONE = 2'd3;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [15:0] excitation;
		logic [3:0]         mode_slot;
		logic [1:0]         coef_select;
		logic signed [31:0] coef_value;
	} request_t;

	typedef struct {
		logic signed [15:0] audio_sample;
		logic               voice_active;
	} sample_result_t;

	// Clock, reset and all block inputs start at known values.
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_SAMPLE;
	logic signed [15:0] excitation = '0;
	logic [3:0]         mode_slot = '0;
	logic [1:0]         coef_select = SEL_FB_ONE;
	logic signed [31:0] coef_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] audio_sample;
	logic               voice_active;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = CFG_SILENCE_LIMIT;
	logic [17:0]        cfg_data = '0;

	// Predictor copy of the coefficient memories, mode states and voice status.
	logic signed [31:0] fb_one_q [NUM_MODES];
	logic signed [31:0] fb_two_q [NUM_MODES];
	logic signed [31:0] gain_q [NUM_MODES];
	logic signed [31:0] y1_q [NUM_MODES];
	logic signed [31:0] y2_q [NUM_MODES];
	logic               voice_on_q;
	logic               release_q;
	logic [17:0]        quiet_q;
	logic [17:0]        limit_q;
	logic [14:0]        threshold_q;

	// Output samples predicted for accepted requests, oldest first.
	sample_result_t expected_samples [$];
	sample_result_t oldest_sample;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int effective_items = 0;
	int fail_count = 0;
	int cycle_count = 0;

	modal_resonator_bank_top #(
		.NUM_MODES(NUM_MODES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.excitation(excitation),
		.mode_slot(mode_slot),
		.coef_select(coef_select),
		.coef_value(coef_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.audio_sample(audio_sample),
		.voice_active(voice_active),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver either stalls at random or, when a hold is requested, keeps
	// the result channel stalled for the whole requested number of cycles.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Every accepted result is matched against the oldest prediction. Signals
	// are read right after the edge, so they still hold their pre-edge values.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				$error("unexpected result: audio_sample %0d, voice_active %0d",
					audio_sample, voice_active);
				fail_count++;
			end else begin
				oldest_sample = expected_samples.pop_front();
				if (audio_sample !== oldest_sample.audio_sample) begin
					$error("audio_sample mismatch: expected %0d, actual %0d",
						oldest_sample.audio_sample, audio_sample);
					fail_count++;
				end
				if (voice_active !== oldest_sample.voice_active) begin
					$error("voice_active mismatch: expected %0d, actual %0d",
						oldest_sample.voice_active, voice_active);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[modal_resonator_bank_top] ERROR");
		$finish;
	end

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	task automatic reset_model();
		int m;
		for (m = 0; m < NUM_MODES; m++) begin
			fb_one_q[m] = '0;
			fb_two_q[m] = '0;
			gain_q[m] = '0;
			y1_q[m] = '0;
			y2_q[m] = '0;
		end
		voice_on_q = 1'b0;
		release_q = 1'b0;
		quiet_q = '0;
		limit_q = MRB_LIMIT_RESET;
		threshold_q = MRB_THRESHOLD_RESET;
	endtask

	// Applies one accepted request to the predictor. Only audio sample
	// requests produce an output sample, which is queued for the checker.
	task automatic predict_sample(input request_t req);
		longint x, acc, y, sum, scaled, smp, mag;
		int m;
		sample_result_t res;
		case (req.cmd)
			CMD_COEF: begin
				// Writes to a slot past the last mode or with the spare
				// selector are dropped.
				if (req.mode_slot < NUM_MODES) begin
					case (req.coef_select)
						SEL_FB_ONE: fb_one_q[req.mode_slot] = req.coef_value;
						SEL_FB_TWO: fb_two_q[req.mode_slot] = req.coef_value;
						SEL_GAIN: gain_q[req.mode_slot] = req.coef_value;
						default: ;
					endcase
				end
			end
			CMD_RELEASE: begin
				release_q = 1'b1;
			end
			CMD_RESTART: begin
				voice_on_q = 1'b1;
				release_q = 1'b0;
				quiet_q = '0;
				for (m = 0; m < NUM_MODES; m++) begin
					y1_q[m] = '0;
					y2_q[m] = '0;
				end
			end
			default: begin
				if (!voice_on_q) begin
					// A silent voice answers with zero and keeps its state.
					res.audio_sample = '0;
					res.voice_active = 1'b0;
				end else begin
					x = longint'(req.excitation);
					sum = 0;
					for (m = 0; m < NUM_MODES; m++) begin
						// Each term is floored on its own before the sum.
						acc = ((longint'(gain_q[m]) * x) >>> 16)
							+ ((longint'(fb_one_q[m]) * longint'(y1_q[m])) >>> 30)
							+ ((longint'(fb_two_q[m]) * longint'(y2_q[m])) >>> 30);
						y = clip32(acc);
						if (release_q)
							y = clip32((y * longint'(MRB_RELEASE_Q30)) >>> 30);
						y2_q[m] = y1_q[m];
						y1_q[m] = 32'(y);
						sum += y;
					end
					// Signed division truncates toward zero, as the scaling needs.
					scaled = sum * longint'(MRB_OUT_SCALE);
					smp = scaled / (longint'(1) <<< MRB_OUT_SHIFT);
					if (smp > 32767)
						smp = 32767;
					if (smp < -32768)
						smp = -32768;
					mag = (smp < 0) ? -smp : smp;
					// A quiet sample past the tolerated run turns the voice off;
					// the sample itself is still delivered.
					if (mag < longint'(threshold_q)) begin
						if (quiet_q >= limit_q)
							voice_on_q = 1'b0;
						else
							quiet_q = quiet_q + 18'd1;
					end else begin
						quiet_q = '0;
					end
					res.audio_sample = 16'(smp);
					res.voice_active = voice_on_q;
				end
				expected_samples.push_back(res);
			end
		endcase
	endtask

	// Offers one request and returns at the edge that accepts it. Valid is
	// left high on return, so a back-to-back request only changes the payload
	// and valid is never dropped and raised in the same time step.
	task automatic issue(input logic [1:0] c, input logic signed [15:0] e,
			input logic [3:0] s, input logic [1:0] sel, input logic signed [31:0] v);
		request_t req;
		req.cmd = c;
		req.excitation = e;
		req.mode_slot = s;
		req.coef_select = sel;
		req.coef_value = v;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		excitation <= e;
		mode_slot <= s;
		coef_select <= sel;
		coef_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_sample(req);
		// Dropped coefficient writes do nothing, so they are not counted.
		if (!(c == CMD_COEF && (s >= NUM_MODES || sel == SEL_NONE)))
			effective_items++;
	endtask

	// Lets the block run dry: all predicted samples delivered, then a pause
	// so that a trailing coefficient, release or restart request is done too.
	task automatic wait_for_quiet_bank();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// One register write. The extra cycle keeps the enable from being lowered
	// and raised in one step when writes follow each other.
	task automatic write_register(input logic [1:0] idx, input logic [17:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_SILENCE_LIMIT)
			limit_q = data;
		else if (idx == CFG_SILENCE_THRESHOLD)
			threshold_q = data[14:0];
	endtask

	// Coefficients that keep a mode stable: feedback two in -0.8 .. -0.1 and
	// feedback one below 1.05 in magnitude. Gains are mostly small, with an
	// occasional full-range value to drive the states into saturation.
	function automatic logic signed [31:0] stable_coef(input logic [1:0] sel);
		logic signed [31:0] mag;
		case (sel)
			SEL_FB_ONE: mag = 32'($urandom_range(1127428915));
			SEL_FB_TWO: return -$signed(32'($urandom_range(858993459, 107374182)));
			default: begin
				if ($urandom_range(7) == 0)
					return $urandom;
				mag = 32'($urandom_range(268435456));
			end
		endcase
		return ($urandom_range(1) == 1) ? -mag : mag;
	endfunction

	// Now and then a request with every field random: stray restarts, releases,
	// coefficient writes to bad slots and samples in the middle of a note.
	task automatic maybe_noise();
		if ($urandom_range(9) == 0)
			issue(2'($urandom), 16'($urandom), 4'($urandom), 2'($urandom), $urandom);
	endtask

	// One well-formed note: restart, a coefficient load, an excitation burst,
	// then a zero tail long enough to decay, with an optional release in it.
	task automatic play_random_note();
		int loads, burst, tail, rel_at, k, m;
		logic signed [15:0] e;
		logic [1:0] sel;
		issue(CMD_RESTART, 16'($urandom), 4'($urandom), 2'($urandom), $urandom);
		if ($urandom_range(4) == 0) begin
			for (m = 0; m < NUM_MODES; m++) begin
				for (k = 0; k < 3; k++)
					issue(CMD_COEF, 16'($urandom), 4'(m), 2'(k), stable_coef(2'(k)));
			end
		end else begin
			loads = $urandom_range(6);
			for (k = 0; k < loads; k++) begin
				sel = 2'($urandom_range(2));
				issue(CMD_COEF, 16'($urandom), 4'($urandom_range(NUM_MODES - 1)), sel,
					stable_coef(sel));
			end
		end
		burst = $urandom_range(6, 1);
		for (k = 0; k < burst; k++) begin
			e = 16'($urandom);
			e = e >>> $urandom_range(12);
			maybe_noise();
			issue(CMD_SAMPLE, e, 4'($urandom), 2'($urandom), $urandom);
		end
		tail = $urandom_range(60, 4);
		rel_at = ($urandom_range(1) == 1) ? $urandom_range(tail - 1) : -1;
		for (k = 0; k < tail; k++) begin
			if (k == rel_at)
				issue(CMD_RELEASE, 16'($urandom), 4'($urandom), 2'($urandom), $urandom);
			maybe_noise();
			issue(CMD_SAMPLE, '0, 4'($urandom), 2'($urandom), $urandom);
		end
	endtask

	// Default registers. Covers a silent voice before any restart, a release
	// while silent, coefficient extremes, dropped coefficient writes, sample
	// extremes that saturate the mode states, release decay and a restart
	// that clears the states but keeps the coefficients.
	task automatic test_inactive_and_commands();
		issue(CMD_SAMPLE, 16'sh7FFF, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_RELEASE, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_SAMPLE, 16'sh8000, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_RESTART, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_COEF, '0, 4'd0, SEL_GAIN, 32'sh7FFFFFFF);
		issue(CMD_COEF, '0, 4'd0, SEL_FB_ONE, 32'sh80000000);
		issue(CMD_COEF, '0, 4'd0, SEL_FB_TWO, 32'sh40000000);
		issue(CMD_COEF, '0, 4'd9, SEL_GAIN, 32'sh80000000);
		issue(CMD_COEF, '0, 4'd9, SEL_FB_TWO, 32'sh7FFFFFFF);
		issue(CMD_COEF, '0, 4'd10, SEL_GAIN, 32'sh40000000);
		issue(CMD_COEF, '0, 4'd15, SEL_FB_ONE, 32'sh7FFFFFFF);
		issue(CMD_COEF, '0, 4'd1, SEL_NONE, 32'sh7FFFFFFF);
		issue(CMD_SAMPLE, 16'sh7FFF, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_SAMPLE, 16'sh8000, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_SAMPLE, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_SAMPLE, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_RELEASE, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_SAMPLE, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_SAMPLE, 16'sd12345, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_RESTART, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_SAMPLE, '0, 4'd0, SEL_FB_ONE, '0);
	endtask

	// A short silence limit: one loud sample, then zeros until the voice
	// turns itself off, then a sample to the silent voice. The writes to the
	// unused register indexes must leave both registers as they are.
	task automatic test_silence_shutdown();
		wait_for_quiet_bank();
		write_register(CFG_SILENCE_LIMIT, 18'd2);
		write_register(CFG_SILENCE_THRESHOLD, 18'd100);
		write_register(CFG_SPARE_LO, 18'd0);
		write_register(CFG_SPARE_HI, 18'h3FFFF);
		issue(CMD_RESTART, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_COEF, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_COEF, '0, 4'd0, SEL_FB_TWO, '0);
		issue(CMD_COEF, '0, 4'd0, SEL_GAIN, 32'sh40000000);
		issue(CMD_COEF, '0, 4'd9, SEL_FB_TWO, '0);
		issue(CMD_COEF, '0, 4'd9, SEL_GAIN, '0);
		issue(CMD_SAMPLE, 16'sd4096, 4'd0, SEL_FB_ONE, '0);
		repeat (3)
			issue(CMD_SAMPLE, '0, 4'd0, SEL_FB_ONE, '0);
		issue(CMD_SAMPLE, 16'sd4096, 4'd0, SEL_FB_ONE, '0);
	endtask

	task automatic run_traffic_phase(input int idle, input int stall,
			input logic [17:0] limit, input logic [17:0] thr);
		int start;
		wait_for_quiet_bank();
		write_register(CFG_SILENCE_LIMIT, limit);
		write_register(CFG_SILENCE_THRESHOLD, thr);
		send_idle_pct = idle;
		stall_pct = stall;
		start = effective_items;
		while (effective_items - start < PHASE_ITEMS)
			play_random_note();
	endtask

	// Random notes under each idle and stall pattern. The first two phases put both
	// registers at their extremes; the threshold write with all data bits
	// set also shows that the bits above the register are dropped.
	task automatic test_random_traffic();
		run_traffic_phase(0, 0, 18'h3FFFF, 18'h3FFFF);
		run_traffic_phase(80, 0, 18'd0, 18'd0);
		run_traffic_phase(0, 80, 18'($urandom_range(30)), 18'($urandom_range(6000, 200)));
		run_traffic_phase(18, 18, 18'($urandom_range(8)), 18'($urandom_range(32767, 500)));
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering samples, so the block fills up and stalls its request channel.
	task automatic test_output_hold();
		wait_for_quiet_bank();
		send_idle_pct = 0;
		stall_pct = 0;
		issue(CMD_RESTART, '0, 4'd0, SEL_FB_ONE, '0);
		hold_request = 300;
		repeat (40)
			issue(CMD_SAMPLE, 16'($urandom), 4'($urandom), 2'($urandom), $urandom);
	endtask

	initial begin
		reset_model();
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_inactive_and_commands();
		test_silence_shutdown();
		test_random_traffic();
		test_output_hold();
		wait_for_quiet_bank();
		if (fail_count == 0)
			$display("[modal_resonator_bank_top] OK");
		else
			$display("[modal_resonator_bank_top] ERROR");
		$finish;
	end

endmodule
